FILE: sv/bet_pkg.sv
// ----------------------------------------------------------------------------
// bet_pkg
// Shared types and constants for the button event tracker.
// ----------------------------------------------------------------------------
package bet_pkg;

    localparam int NUM_BUTTONS  = 8;
    localparam int IDX_W        = 3;
    localparam int TIME_W       = 32;
    localparam int COUNT_W      = 4;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 8;
    localparam int IN_TDATA_W   = 48;
    localparam int OUT_TDATA_W  = 56;

    localparam logic [COUNT_W-1:0]    COUNT_RESET      = 4'd8;
    localparam logic [NUM_BUTTONS-1:0] ACTIVE_LOW_RESET = 8'h00;

    // Item kinds carried in the mode field.
    typedef enum logic [1:0] {
        MODE_SAMPLE  = 2'd0,
        MODE_CONSUME = 2'd1,
        MODE_QUERY   = 2'd2
    } mode_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BUTTON_COUNT = 1'b0,
        REG_ACTIVE_LOW   = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [IDX_W-1:0]       button_index;
        logic [TIME_W-1:0]      timestamp;
        logic [NUM_BUTTONS-1:0] pin_levels;
        logic [1:0]             mode;
    } item_t;

    typedef struct packed {
        logic [TIME_W-1:0]      held_time;
        logic                   held_valid;
        logic [NUM_BUTTONS-1:0] released_events;
        logic [NUM_BUTTONS-1:0] pressed_events;
    } result_t;

    typedef struct packed {
        logic [COUNT_W-1:0]     button_count;
        logic [NUM_BUTTONS-1:0] active_low_mask;
    } cfg_t;

endpackage

FILE: sv/bet_tracker.sv
// ----------------------------------------------------------------------------
// bet_tracker
// Button state and press start times; produces one result per step.
// ----------------------------------------------------------------------------
module bet_tracker
    import bet_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    logic [NUM_BUTTONS-1:0] held_reg, held_next;
    logic [NUM_BUTTONS-1:0] press_reg, press_next;
    logic [NUM_BUTTONS-1:0] release_reg, release_next;
    logic [NUM_BUTTONS-1:0] consumed_reg, consumed_next;
    logic [NUM_BUTTONS-1:0] tracked;
    logic [NUM_BUTTONS-1:0] active;
    logic [NUM_BUTTONS-1:0] start_we;
    logic [TIME_W-1:0]      start_reg [NUM_BUTTONS];
    logic [TIME_W-1:0]      start_sel;
    logic                   valid;

    always_comb
    begin
        held_next     = held_reg;
        press_next    = press_reg;
        release_next  = release_reg;
        consumed_next = consumed_reg;
        start_we      = '0;
        active        = item.pin_levels ^ cfg.active_low_mask;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            tracked[i] = (COUNT_W'(i) < cfg.button_count);
        end
        case (item.mode)
            MODE_SAMPLE:
            begin
                press_next   = '0;
                release_next = '0;
                for (int i = 0; i < NUM_BUTTONS; i++)
                begin
                    if (tracked[i])
                    begin
                        if (!held_reg[i] && active[i])
                        begin
                            press_next[i]    = 1'b1;
                            consumed_next[i] = 1'b0;
                            held_next[i]     = 1'b1;
                            start_we[i]      = 1'b1;
                        end
                        else if (held_reg[i] && !active[i])
                        begin
                            held_next[i]    = 1'b0;
                            release_next[i] = 1'b1;
                        end
                        else if (!active[i])
                        begin
                            consumed_next[i] = 1'b0;
                        end
                    end
                end
            end
            MODE_CONSUME:
            begin
                consumed_next[item.button_index] = 1'b1;
            end
            default:
            begin
            end
        endcase

        // A press in this very item starts the clock at the current time.
        start_sel = start_we[item.button_index] ? item.timestamp
                                                : start_reg[item.button_index];
        valid = held_next[item.button_index] && !consumed_next[item.button_index];

        result.pressed_events  = press_next & ~consumed_next;
        result.released_events = release_next & ~consumed_next;
        result.held_valid      = valid;
        result.held_time       = valid ? (item.timestamp - start_sel) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg     <= '0;
            press_reg    <= '0;
            release_reg  <= '0;
            consumed_reg <= '0;
        end
        else if (step)
        begin
            held_reg     <= held_next;
            press_reg    <= press_next;
            release_reg  <= release_next;
            consumed_reg <= consumed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            if (step && start_we[i])
            begin
                start_reg[i] <= item.timestamp;
            end
        end
    end

`ifndef SYNTHESIS
    a_events_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        (press_reg & release_reg) == '0)
        else $error("press and release events overlap");

    a_press_is_held: assert property (@(posedge clk) disable iff (!rst_n)
        (press_reg & ~held_reg) == '0)
        else $error("press event on a button that is not held");

    a_release_not_held: assert property (@(posedge clk) disable iff (!rst_n)
        (release_reg & held_reg) == '0)
        else $error("release event on a button that is still held");
`endif

endmodule

FILE: sv/button_event_tracker.sv
// ----------------------------------------------------------------------------
// button_event_tracker
// Press/release edge detection and held-time reporting for eight buttons.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Contents
//   s_axis    in         one item: mode, pin levels, timestamp, button index
//   m_axis    out        one result: event masks, held flag, held time
//   cfg       in         register writes: button_count, active_low_mask
//
// One item is taken every clock cycle while m_axis_tready stays high. The edge that
// accepts an item loads the input register, and the edge that moves it on loads
// its result into the result register, once that register is free or drains.
// The per-item work is a set of per-button bit updates and one 32-bit
// subtraction, all between the input register and the result register.
// When the result register is full and not taken, the input register holds
// its item and s_axis_tready drops only once both registers are full.
// Reset clears the button state and the handshake, and returns button_count
// to 8 and active_low_mask to zero. Press start times are not reset.
//
module button_event_tracker
    import bet_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [1:0] mode, [9:2] pin_levels, [41:10] timestamp, [44:42] button_index
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] pressed_events, [15:8] released_events, [16] held_valid,
    // [48:17] held_time
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t result_reg;
    logic    result_valid_reg;
    result_t result_next;
    logic    advance;
    logic    accept;

    // The held item moves on whenever the result register is free or drains.
    assign advance       = item_valid_reg && (!result_valid_reg || m_axis_tready);
    assign s_axis_tready = !item_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.button_count    <= COUNT_RESET;
            cfg_reg.active_low_mask <= ACTIVE_LOW_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BUTTON_COUNT: cfg_reg.button_count    <= cfg_data[COUNT_W-1:0];
                REG_ACTIVE_LOW:   cfg_reg.active_low_mask <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                item_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_t'(s_axis_tdata[$bits(item_t)-1:0]);
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    bet_tracker u_tracker (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .cfg    (cfg_reg),
        .result (result_next)
    );

    assign m_axis_tvalid = result_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, result_reg};

`ifndef SYNTHESIS
    a_result_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !m_axis_tready) |=>
            (result_valid_reg && $stable(result_reg)))
        else $error("result register changed while stalled");

    a_item_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !advance) |=> (item_valid_reg && $stable(item_reg)))
        else $error("input register lost an item that had not moved on");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !item_valid_reg |-> s_axis_tready)
        else $error("input side stalled with an empty input register");
`endif

endmodule
